/* sv/srclx_pkg.sv */
// Shared types, constants and token lookup functions for the source lexer.
// No dependencies; imported by every lexer module.
package srclx_pkg;

	localparam int OFFSET_BITS   = 24;
	localparam int LENGTH_BITS   = 16;
	localparam int LINE_BITS     = 16;
	localparam int PREFIX_DEPTH  = 6;
	localparam int PFX_IDX_BITS  = $clog2(PREFIX_DEPTH);
	localparam int QUEUE_DEPTH   = 2;
	localparam int QPTR_BITS     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_BITS     = $clog2(QUEUE_DEPTH + 1);
	localparam int SLOTS         = 3;
	localparam int SLOT_BITS     = $clog2(SLOTS);

	localparam logic [LENGTH_BITS-1:0] LEN_MAX  = {LENGTH_BITS{1'b1}};
	localparam logic [LINE_BITS-1:0]   LINE_MAX = {LINE_BITS{1'b1}};

	localparam logic [4:0] K_IDENT   = 5'd0;
	localparam logic [4:0] K_NUMBER  = 5'd1;
	localparam logic [4:0] K_STRING  = 5'd2;
	localparam logic [4:0] K_KW0     = 5'd3;
	localparam logic [4:0] K_OP0     = 5'd11;
	localparam logic [4:0] K_UNKNOWN = 5'd27;
	localparam logic [4:0] K_END     = 5'd28;

	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_SQUOTE = 8'h27;
	localparam logic [7:0] CH_DOT    = 8'h2E;
	localparam logic [7:0] CH_BSLASH = 8'h5C;

	typedef enum logic [2:0] {
		M_IDLE, M_IDENT, M_INT, M_FRAC, M_STR, M_ESC, M_RUN
	} mode_t;

	typedef logic [PREFIX_DEPTH-1:0][7:0] prefix_t;

	typedef struct packed {
		logic [7:0] text_byte;
		logic       final_byte;
	} in_item_t;

	typedef struct packed {
		logic [4:0]             token_kind;
		logic [OFFSET_BITS-1:0] start_offset;
		logic [LENGTH_BITS-1:0] token_length;
		logic [LINE_BITS-1:0]   line_number;
		logic                   stream_done;
	} out_item_t;

	typedef struct packed {
		logic [SLOT_BITS-1:0]      count;
		out_item_t [SLOTS-1:0]     slot;
	} bundle_t;

	typedef struct packed {
		logic full;
		logic empty;
	} qstat_t;

	// byte-reversed text: byte 0 of the word sits in the low byte
	localparam prefix_t    KW_TXT [8] = '{"fi", "neht", "esle", "fiesle",
		"dne", "elihw", "rof", "od"};
	localparam logic [2:0] KW_LEN [8] = '{3'd2, 3'd4, 3'd4, 3'd6, 3'd3, 3'd5, 3'd3, 3'd2};

	localparam prefix_t    OP_TXT [16] = '{"+", "-", "*", "/", "<", ">",
		"=<", "=>", "==", "=!", "(", ")", "{", "}", "[", "]"};
	localparam logic [2:0] OP_LEN [16] = '{3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1,
		3'd2, 3'd2, 3'd2, 3'd2, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1};

	function automatic logic is_alpha(input logic [7:0] b);
		return (b >= 8'h61 && b <= 8'h7A) || (b >= 8'h41 && b <= 8'h5A);
	endfunction

	function automatic logic is_digit(input logic [7:0] b);
		return b >= 8'h30 && b <= 8'h39;
	endfunction

	function automatic logic is_blank(input logic [7:0] b);
		return b == CH_SPACE || b == CH_LF || b == CH_TAB || b == CH_CR;
	endfunction

	function automatic logic word_eq(input prefix_t p, input prefix_t w,
			input logic [2:0] n);
		logic eq;
		eq = 1'b1;
		for (int j = 0; j < PREFIX_DEPTH; j++) begin
			if (j < int'(n) && p[j] != w[j])
				eq = 1'b0;
		end
		return eq;
	endfunction

	function automatic logic [4:0] classify(input mode_t m,
			input logic [LENGTH_BITS-1:0] len, input prefix_t p);
		logic [4:0] k;
		logic       fits;
		logic [2:0] n;
		fits = len <= LENGTH_BITS'(PREFIX_DEPTH);
		n    = len[2:0];
		case (m) inside
			M_IDENT: begin
				k = K_IDENT;
				for (int i = 0; i < 8; i++) begin
					if (fits && n == KW_LEN[i] && word_eq(p, KW_TXT[i], n))
						k = K_KW0 + 5'(i);
				end
			end
			M_INT, M_FRAC: k = K_NUMBER;
			M_STR, M_ESC: k = K_STRING;
			default: begin
				k = K_UNKNOWN;
				for (int i = 0; i < 16; i++) begin
					if (fits && n == OP_LEN[i] && word_eq(p, OP_TXT[i], n))
						k = K_OP0 + 5'(i);
				end
			end
		endcase
		return k;
	endfunction

endpackage

/* sv/srclx_front.sv */
// Front end: takes source bytes, runs the lexer state machine and builds
// up to three classified results per byte. Depends on srclx_pkg.
module srclx_front import srclx_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     src_valid,
	output logic     src_stall,
	input  in_item_t src_data,
	input  qstat_t   qstat,
	output logic     push,
	output bundle_t  bundle
);

	mode_t                  mode_q, mode_a;
	logic                   dq_q, dq_a;
	logic [OFFSET_BITS-1:0] pos_q, pos_n, start_q, start_a;
	logic [LENGTH_BITS-1:0] len_q, len_a, len_inc, len1;
	logic [LINE_BITS-1:0]   line_q, line_n;
	prefix_t                pfx_q, pfx_a;
	logic                   used, close1, close2, accept;
	logic [7:0]             b, quote;
	logic                   fin;
	out_item_t              t1, t2, te;

	assign b         = src_data.text_byte;
	assign fin       = src_data.final_byte;
	assign src_stall = qstat.full;
	assign accept    = src_valid && !qstat.full;
	assign quote     = dq_q ? CH_DQUOTE : CH_SQUOTE;
	assign len_inc   = (len_q == LEN_MAX) ? len_q : len_q + 1'b1;
	assign pos_n     = pos_q + 1'b1;

	always_comb begin
		mode_a  = mode_q;
		dq_a    = dq_q;
		len_a   = len_q;
		pfx_a   = pfx_q;
		start_a = start_q;
		line_n  = line_q;
		used    = 1'b0;
		close1  = 1'b0;
		len1    = len_q;
		unique case (mode_q)
			M_IDENT: begin
				if (is_alpha(b) || is_digit(b)) used = 1'b1;
				else close1 = 1'b1;
			end
			M_INT: begin
				if (is_digit(b)) begin
					used = 1'b1;
				end else if (b == CH_DOT) begin
					used   = 1'b1;
					mode_a = M_FRAC;
				end else begin
					close1 = 1'b1;
				end
			end
			M_FRAC: begin
				if (is_digit(b)) used = 1'b1;
				else close1 = 1'b1;
			end
			M_RUN: begin
				if (!is_blank(b)) used = 1'b1;
				else close1 = 1'b1;
			end
			M_STR: begin
				used = 1'b1;
				if (b == quote) begin
					close1 = 1'b1;
					len1   = len_inc;
				end else if (b == CH_BSLASH) begin
					mode_a = M_ESC;
				end
			end
			M_ESC: begin
				used   = 1'b1;
				mode_a = M_STR;
			end
			default: mode_a = M_IDLE;
		endcase
		if (used) begin
			if (len_q < LENGTH_BITS'(PREFIX_DEPTH))
				pfx_a[len_q[PFX_IDX_BITS-1:0]] = b;
			len_a = len_inc;
		end
		if (close1)
			mode_a = M_IDLE;
		if (!used) begin
			if (is_blank(b)) begin
				if (b == CH_LF && line_q != LINE_MAX)
					line_n = line_q + 1'b1;
			end else begin
				start_a  = pos_q;
				len_a    = LENGTH_BITS'(1);
				pfx_a[0] = b;
				if (is_alpha(b)) begin
					mode_a = M_IDENT;
				end else if (is_digit(b)) begin
					mode_a = M_INT;
				end else if (b == CH_DQUOTE || b == CH_SQUOTE) begin
					mode_a = M_STR;
					dq_a   = (b == CH_DQUOTE);
				end else begin
					mode_a = M_RUN;
				end
			end
		end
	end

	assign close2 = fin && mode_a != M_IDLE;

	always_comb begin
		t1 = '{token_kind: classify(mode_q, len_q, pfx_q), start_offset: start_q,
			token_length: len1, line_number: line_q, stream_done: 1'b0};
		t2 = '{token_kind: classify(mode_a, len_a, pfx_a), start_offset: start_a,
			token_length: len_a, line_number: line_n, stream_done: 1'b0};
		te = '{token_kind: K_END, start_offset: pos_n,
			token_length: '0, line_number: line_n, stream_done: 1'b1};
		bundle.count = SLOT_BITS'(close1) + SLOT_BITS'(close2) + SLOT_BITS'(fin);
		bundle.slot  = {te, te, te};
		if (close1) begin
			bundle.slot[0] = t1;
			bundle.slot[1] = close2 ? t2 : te;
		end else if (close2) begin
			bundle.slot[0] = t2;
		end
	end

	assign push = accept && (close1 || close2 || fin);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= M_IDLE;
			dq_q    <= 1'b0;
			pos_q   <= '0;
			start_q <= '0;
			len_q   <= '0;
			line_q  <= LINE_BITS'(1);
		end else if (accept) begin
			if (fin) begin
				mode_q  <= M_IDLE;
				dq_q    <= 1'b0;
				pos_q   <= '0;
				start_q <= '0;
				len_q   <= '0;
				line_q  <= LINE_BITS'(1);
			end else begin
				mode_q  <= mode_a;
				dq_q    <= dq_a;
				pos_q   <= pos_n;
				start_q <= start_a;
				len_q   <= len_a;
				line_q  <= line_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept)
			pfx_q <= pfx_a;
	end

endmodule

/* sv/srclx_queue.sv */
// Short queue of result bundles between lexer front and back ends.
// Depends on srclx_pkg.
module srclx_queue import srclx_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  bundle_t push_data,
	input  logic    pop,
	output bundle_t head,
	output qstat_t  qstat
);

	bundle_t              mem_q [QUEUE_DEPTH];
	logic [QPTR_BITS-1:0] wr_q, rd_q;
	logic [QCNT_BITS-1:0] cnt_q;

	function automatic logic [QPTR_BITS-1:0] bump(input logic [QPTR_BITS-1:0] p);
		return (p == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign head        = mem_q[rd_q];
	assign qstat.full  = cnt_q == QCNT_BITS'(QUEUE_DEPTH);
	assign qstat.empty = cnt_q == '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= bump(wr_q);
			if (pop)
				rd_q <= bump(rd_q);
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= push_data;
	end

`ifndef SYNTH
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !qstat.full) else $error("bundle queue overflow");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !qstat.empty) else $error("bundle queue underflow");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= QCNT_BITS'(QUEUE_DEPTH)) else $error("bundle count out of range");
	a_count_up: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |=> cnt_q == $past(cnt_q) + 1'b1) else $error("bundle count lost");
`endif

endmodule

/* sv/srclx_back.sv */
// Back end: walks the slots of the head bundle and drives the output
// register, one result per transfer. Depends on srclx_pkg.
module srclx_back import srclx_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  bundle_t   head,
	input  qstat_t    qstat,
	output logic      pop,
	output logic      tok_valid,
	input  logic      tok_stall,
	output out_item_t tok_data
);

	logic [SLOT_BITS-1:0] idx_q;
	logic                 load, last;

	assign load = !qstat.empty && (!tok_valid || !tok_stall);
	assign last = idx_q == head.count - 1'b1;
	assign pop  = load && last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q     <= '0;
			tok_valid <= 1'b0;
		end else if (load) begin
			tok_valid <= 1'b1;
			idx_q     <= last ? '0 : idx_q + 1'b1;
		end else if (!tok_stall) begin
			tok_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load)
			tok_data <= head.slot[idx_q];
	end

endmodule

/* sv/source_lexer.sv */
// Path: a byte's results go into the bundle queue, then into the output register.
// Throughput: one byte per cycle while tok_stall is low and each byte yields
// at most one result; a byte that yields k results (up to three) holds the
// single output register for k transfers, with a two-bundle queue absorbing the burst.
// Reset: asynchronous, active low; offset 0, line 1, lexer idle, queue empty.
module source_lexer import srclx_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      src_valid,
	output logic      src_stall,
	input  in_item_t  src_data,
	output logic      tok_valid,
	input  logic      tok_stall,
	output out_item_t tok_data
);

	logic    push, pop;
	bundle_t bundle, head;
	qstat_t  qstat;

	srclx_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.src_valid (src_valid),
		.src_stall (src_stall),
		.src_data  (src_data),
		.qstat     (qstat),
		.push      (push),
		.bundle    (bundle)
	);

	srclx_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (bundle),
		.pop       (pop),
		.head      (head),
		.qstat     (qstat)
	);

	srclx_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.qstat     (qstat),
		.pop       (pop),
		.tok_valid (tok_valid),
		.tok_stall (tok_stall),
		.tok_data  (tok_data)
	);

endmodule

/* bench/lexer_check.sv */
`timescale 1ns / 100ps
// Token checker for source_lexer: watches the byte and token channels, predicts
// the token stream byte by byte and compares every token transfer in order.
// Depends on srclx_pkg for the payload types, token codes and character codes.
module lexer_check import srclx_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      src_valid,
	input  logic      src_stall,
	input  in_item_t  src_data,
	input  logic      tok_valid,
	input  logic      tok_stall,
	input  out_item_t tok_data,
	output int        fail_count,
	output int        pending
);

	string kw_words [8] = '{"if", "then", "else", "elseif", "end", "while", "for", "do"};
	string op_words [16] = '{"+", "-", "*", "/", "<", ">", "<=", ">=", "==", "!=",
		"(", ")", "{", "}", "[", "]"};

	mode_t                  lx_mode;
	logic                   lx_dq;
	logic [OFFSET_BITS-1:0] lx_pos;
	logic [OFFSET_BITS-1:0] lx_start;
	logic [LENGTH_BITS-1:0] lx_len;
	logic [LINE_BITS-1:0]   lx_line;
	logic [7:0]             lx_head [PREFIX_DEPTH];

	out_item_t expected_tokens [$];
	out_item_t want;
	int        errors;

	function automatic logic alpha_ch(input logic [7:0] b);
		return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
	endfunction

	function automatic logic digit_ch(input logic [7:0] b);
		return b >= "0" && b <= "9";
	endfunction

	function automatic logic blank_ch(input logic [7:0] b);
		return b == CH_SPACE || b == CH_TAB || b == CH_CR || b == CH_LF;
	endfunction

	function automatic void take(input logic [7:0] b);
		if (lx_len < PREFIX_DEPTH)
			lx_head[lx_len[PFX_IDX_BITS-1:0]] = b;
		if (lx_len != LEN_MAX)
			lx_len++;
	endfunction

	function automatic logic head_is(input string w);
		if (int'(lx_len) != w.len())
			return 1'b0;
		for (int i = 0; i < w.len(); i++) begin
			if (lx_head[i] != w[i])
				return 1'b0;
		end
		return 1'b1;
	endfunction

	function automatic logic [4:0] token_class();
		logic [4:0] k;
		case (lx_mode)
			M_IDENT: begin
				k = K_IDENT;
				for (int i = 0; i < 8; i++) begin
					if (head_is(kw_words[i]))
						k = K_KW0 + 5'(i);
				end
			end
			M_INT, M_FRAC: k = K_NUMBER;
			M_STR, M_ESC: k = K_STRING;
			default: begin
				k = K_UNKNOWN;
				for (int i = 0; i < 16; i++) begin
					if (head_is(op_words[i]))
						k = K_OP0 + 5'(i);
				end
			end
		endcase
		return k;
	endfunction

	function automatic void expect_token(input logic [4:0] kind,
			input logic [OFFSET_BITS-1:0] start, input logic [LENGTH_BITS-1:0] len,
			input logic last);
		out_item_t t;
		t.token_kind   = kind;
		t.start_offset = start;
		t.token_length = len;
		t.line_number  = lx_line;
		t.stream_done  = last;
		expected_tokens.push_back(t);
	endfunction

	function automatic void close_token();
		expect_token(token_class(), lx_start, lx_len, 1'b0);
		lx_mode = M_IDLE;
	endfunction

	function automatic void reset_stream();
		lx_mode  = M_IDLE;
		lx_dq    = 1'b0;
		lx_pos   = '0;
		lx_start = '0;
		lx_len   = '0;
		lx_line  = LINE_BITS'(1);
	endfunction

	function automatic void tokenize_byte(input logic [7:0] b, input logic fin);
		logic used;
		used = 1'b0;
		case (lx_mode)
			M_IDENT: begin
				if (alpha_ch(b) || digit_ch(b)) begin
					take(b);
					used = 1'b1;
				end else
					close_token();
			end
			M_INT: begin
				if (digit_ch(b)) begin
					take(b);
					used = 1'b1;
				end else if (b == CH_DOT) begin
					take(b);
					lx_mode = M_FRAC;
					used = 1'b1;
				end else
					close_token();
			end
			M_FRAC: begin
				if (digit_ch(b)) begin
					take(b);
					used = 1'b1;
				end else
					close_token();
			end
			M_RUN: begin
				if (!blank_ch(b)) begin
					take(b);
					used = 1'b1;
				end else
					close_token();
			end
			M_STR: begin
				take(b);
				used = 1'b1;
				if (b == (lx_dq ? CH_DQUOTE : CH_SQUOTE))
					close_token();
				else if (b == CH_BSLASH)
					lx_mode = M_ESC;
			end
			M_ESC: begin
				take(b);
				used = 1'b1;
				lx_mode = M_STR;
			end
			default: lx_mode = M_IDLE;
		endcase
		if (!used) begin
			if (blank_ch(b)) begin
				if (b == CH_LF && lx_line != LINE_MAX)
					lx_line++;
			end else begin
				lx_start = lx_pos;
				lx_len = '0;
				take(b);
				if (alpha_ch(b))
					lx_mode = M_IDENT;
				else if (digit_ch(b))
					lx_mode = M_INT;
				else if (b == CH_DQUOTE || b == CH_SQUOTE) begin
					lx_mode = M_STR;
					lx_dq = (b == CH_DQUOTE);
				end else
					lx_mode = M_RUN;
			end
		end
		lx_pos++;
		if (fin) begin
			if (lx_mode != M_IDLE)
				close_token();
			expect_token(K_END, lx_pos, '0, 1'b1);
			reset_stream();
		end
	endfunction

	function automatic void flag(input string what, input out_item_t exp_tok,
			input out_item_t got);
		errors++;
		if (errors <= 10) begin
			$display("%s: expected kind %0d off %0d len %0d line %0d done %0b", what,
				exp_tok.token_kind, exp_tok.start_offset, exp_tok.token_length,
				exp_tok.line_number, exp_tok.stream_done);
			$display("%s: got      kind %0d off %0d len %0d line %0d done %0b", what,
				got.token_kind, got.start_offset, got.token_length,
				got.line_number, got.stream_done);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reset_stream();
			for (int i = 0; i < PREFIX_DEPTH; i++)
				lx_head[i] = '0;
			expected_tokens.delete();
			errors = 0;
		end else begin
			if (tok_valid && !tok_stall) begin
				if (expected_tokens.size() == 0)
					flag("unexpected token", '0, tok_data);
				else begin
					want = expected_tokens.pop_front();
					if (want.token_kind !== tok_data.token_kind ||
							want.start_offset !== tok_data.start_offset ||
							want.token_length !== tok_data.token_length ||
							want.line_number !== tok_data.line_number ||
							want.stream_done !== tok_data.stream_done)
						flag("token mismatch", want, tok_data);
				end
			end
			if (src_valid && !src_stall)
				tokenize_byte(src_data.text_byte, src_data.final_byte);
		end
		fail_count <= errors;
		pending <= expected_tokens.size();
	end

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 100ps
// Testbench top for source_lexer: feeds generated source text with random
// gaps and token stalls, and reports the verdict from lexer_check.
// Depends on srclx_pkg, source_lexer and lexer_check.
module tb_top;
	import srclx_pkg::*;

	logic      clk = 1'b0;
	logic      arst_n;
	logic      src_valid;
	logic      src_stall;
	in_item_t  src_data;
	logic      tok_valid;
	logic      tok_stall;
	out_item_t tok_data;
	int        fail_count;
	int        pending;

	bit calm;
	int random_bytes;
	int kw_turn;
	int op_turn;

	string kw_words [8] = '{"if", "then", "else", "elseif", "end", "while", "for", "do"};
	string op_words [16] = '{"+", "-", "*", "/", "<", ">", "<=", ">=", "==", "!=",
		"(", ")", "{", "}", "[", "]"};
	string op_misses [7] = '{"=", "!", "=<", "<<", "()", "+-", "==="};
	string letters = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ";
	string alnum = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789";
	logic [7:0] blank_set [4] = '{CH_SPACE, CH_TAB, CH_CR, CH_LF};

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	source_lexer DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.src_valid (src_valid),
		.src_stall (src_stall),
		.src_data  (src_data),
		.tok_valid (tok_valid),
		.tok_stall (tok_stall),
		.tok_data  (tok_data)
	);

	lexer_check u_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.src_valid  (src_valid),
		.src_stall  (src_stall),
		.src_data   (src_data),
		.tok_valid  (tok_valid),
		.tok_stall  (tok_stall),
		.tok_data   (tok_data),
		.fail_count (fail_count),
		.pending    (pending)
	);

	task automatic send_byte(input logic [7:0] b, input logic fin);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 18);
		if (gap > 0) begin
			src_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		src_valid <= 1'b1;
		src_data <= '{text_byte: b, final_byte: fin};
		do @(posedge clk); while (src_stall);
	endtask

	task automatic send_text(input string s, input logic fin_last);
		for (int i = 0; i < s.len(); i++)
			send_byte(s[i], fin_last && i == s.len() - 1);
	endtask

	task automatic put(input logic [7:0] b);
		send_byte(b, $urandom_range(0, 29) == 0);
		random_bytes++;
	endtask

	task automatic random_token();
		logic [7:0] word [$];
		logic [7:0] q;
		logic [7:0] b;
		string      w;
		int         n;
		w = "";
		case ($urandom_range(0, 12))
			0, 1: begin
				w = kw_words[kw_turn % 8];
				kw_turn++;
			end
			2, 3: begin
				w = op_words[op_turn % 16];
				op_turn++;
			end
			4: begin
				w = kw_words[$urandom_range(0, 7)];
				n = $urandom_range(0, alnum.len() - 1);
				if ($urandom_range(0, 1))
					w = w.substr(0, w.len() - 2);
				else
					w = {w, alnum.substr(n, n)};
			end
			5, 6: begin
				word.push_back(letters[$urandom_range(0, letters.len() - 1)]);
				repeat ($urandom_range(0, 7))
					word.push_back(alnum[$urandom_range(0, alnum.len() - 1)]);
			end
			7: begin
				repeat ($urandom_range(1, 4))
					word.push_back(8'($urandom_range(48, 57)));
				if ($urandom_range(0, 1)) begin
					word.push_back(CH_DOT);
					repeat ($urandom_range(0, 3))
						word.push_back(8'($urandom_range(48, 57)));
				end
			end
			8, 9: begin
				q = $urandom_range(0, 1) ? CH_DQUOTE : CH_SQUOTE;
				word.push_back(q);
				repeat ($urandom_range(0, 6)) begin
					case ($urandom_range(0, 7))
						0: begin
							word.push_back(CH_BSLASH);
							word.push_back(8'($urandom_range(0, 255)));
						end
						1: word.push_back(q == CH_DQUOTE ? CH_SQUOTE : CH_DQUOTE);
						2: word.push_back(CH_LF);
						default: begin
							b = 8'($urandom_range(32, 126));
							word.push_back((b == q || b == CH_BSLASH) ? 8'h7A : b);
						end
					endcase
				end
				if ($urandom_range(0, 7) != 0)
					word.push_back(q);
			end
			10: begin
				repeat ($urandom_range(1, 4)) begin
					b = 8'($urandom_range(0, 255));
					word.push_back(b <= CH_SPACE ? (b | 8'h80) : b);
				end
			end
			11: w = op_misses[$urandom_range(0, 6)];
			default: word.push_back(8'($urandom_range(0, 255)));
		endcase
		for (int i = 0; i < w.len(); i++)
			put(w[i]);
		foreach (word[i])
			put(word[i]);
		repeat ($urandom_range(0, 3))
			put(blank_set[$urandom_range(0, 3)]);
	endtask

	initial begin
		int hold;
		forever begin
			hold = calm ? 0 : $urandom_range(0, 18);
			if (hold > 0) begin
				tok_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			tok_stall <= 1'b0;
			do @(posedge clk); while (!tok_valid);
		end
	end

	initial begin
		#10_000_000;
		$display("FAILED: results differ");
		$finish;
	end

	initial begin
		int drain;
		arst_n <= 1'b0;
		src_valid <= 1'b0;
		src_data <= '0;
		calm = 1'b0;
		random_bytes = 0;
		kw_turn = 0;
		op_turn = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_text("elseif\n!= 3.14", 1'b1);
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_text(" 1.", 1'b1);
		send_text("\"a\\", 1'b1);
		send_text(" ", 1'b1);

		while (random_bytes < 350) begin
			if ($urandom_range(0, 11) == 0)
				calm = !calm;
			random_token();
		end
		calm = 1'b0;
		send_text(" ", 1'b1);
		src_valid <= 1'b0;

		@(posedge clk);
		drain = 0;
		while (pending != 0 && drain < 2000) begin
			@(posedge clk);
			drain++;
		end
		repeat (8) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
